FILE: rtl/core/hs_pkg.sv
`default_nettype none

package hs_pkg;

  // Capacity of one set and the widths that follow from it.
  localparam int unsigned DEPTH = 32;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned LW    = AW + 2;

  // One input word.
  typedef struct packed {
    logic signed [31:0] data_value;
    logic               last_in;
  } hs_in_t;

  // One result word.
  typedef struct packed {
    logic signed [31:0] sorted_value;
    logic               last_out;
    logic               overflow;
  } hs_out_t;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_COLLECT,
    S_LOAD,
    S_LATCH,
    S_CHILD,
    S_CMP,
    S_SWAP_RD,
    S_SWAP_WR,
    S_EMIT_RD,
    S_EMIT_WAIT
  } hs_state_e;

endpackage

`default_nettype wire

FILE: rtl/core/heap_sorter_core.sv
// Heap sorter core.
// Input channel: in_valid_i / in_stall_o carry one signed value per word in
// in_data_i; the word with last_in set closes the set and starts the sort.
// Up to DEPTH values are stored; further words are dropped and every result
// of that set then carries overflow. The set is never empty at sort time.
// Output channel: out_valid_o / out_stall_i carry the set in ascending
// order, last_out marking the greatest value.
// Flow: a word without last_in is taken without stalling the input. After
// the closing word the core stalls its input while it sorts and emits the
// set. The sort runs one shared three-way compare unit over a two-read,
// one-write memory: each sift-down fetches its start value (S_LOAD, S_LATCH
// to build; S_SWAP_RD, S_SWAP_WR to extract), then reads and compares the
// children (S_CHILD, S_CMP) per heap level, with about n/2 sift-downs to
// build the heap and n-1 to extract. Emission reads each word (S_EMIT_RD)
// and hands it to the output register (S_EMIT_WAIT) once that is free.
// Output stall: the output register holds its word; emission waits for it.
// Once the last result is in the output register, input words are taken
// again while that result is still waiting.
// Reset: the set is emptied, the overflow flag cleared, no output is valid.
// Memory contents are not cleared; only entries of the current set are used.
`default_nettype none

module heap_sorter_core (
  input  wire             clk_i,
  input  wire             rst_ni,
  input  wire             in_valid_i,
  output logic            in_stall_o,
  input  hs_pkg::hs_in_t  in_data_i,
  output logic            out_valid_o,
  input  wire             out_stall_i,
  output hs_pkg::hs_out_t out_data_o
);
  import hs_pkg::*;

  // Element memory: one write port, two registered read ports.
  logic signed [31:0] mem [DEPTH];
  logic               we;
  logic [AW-1:0]      wa;
  logic signed [31:0] wd;
  logic [AW-1:0]      ra_a, ra_b;
  logic signed [31:0] rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_a_q <= mem[ra_a];
    rd_b_q <= mem[ra_b];
  end

  // Sequencer and datapath registers.
  hs_state_e          state_q, state_d;
  logic [CW-1:0]      count_q, count_d;
  logic               drop_q, drop_d;
  logic               extract_q, extract_d;
  logic [AW-1:0]      idx_q, idx_d;
  logic [AW-1:0]      node_q, node_d;
  logic signed [31:0] val_q, val_d;
  logic               out_vld_q, out_vld_d;
  hs_out_t            out_q, out_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_COLLECT;
      count_q   <= '0;
      drop_q    <= 1'b0;
      extract_q <= 1'b0;
      idx_q     <= '0;
      node_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      drop_q    <= drop_d;
      extract_q <= extract_d;
      idx_q     <= idx_d;
      node_q    <= node_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    out_q <= out_d;
  end

  // Child addresses and the heap size of the running sift-down.
  logic [LW-1:0] left, right, size;
  logic          left_ok, right_ok;
  assign left     = (LW'(node_q) << 1) + LW'(1);
  assign right    = left + LW'(1);
  assign size     = extract_q ? LW'(idx_q) : LW'(count_q);
  assign left_ok  = left < size;
  assign right_ok = right < size;

  // Shared three-way compare of the carried value and its two children.
  logic v_gt_l, v_gt_r, l_gt_r, pick_right, big_gt_r;
  assign v_gt_l     = val_q > rd_a_q;
  assign v_gt_r     = val_q > rd_b_q;
  assign l_gt_r     = rd_a_q > rd_b_q;
  assign big_gt_r   = v_gt_l ? v_gt_r : l_gt_r;
  assign pick_right = right_ok && !big_gt_r;

  logic          in_acc, out_free, emit_last;
  logic [CW-1:0] count_inc;
  assign in_acc    = in_valid_i && (state_q == S_COLLECT);
  assign out_free  = !out_vld_q || !out_stall_i;
  assign emit_last = (CW'(idx_q) + CW'(1)) == count_q;
  assign count_inc = count_q + CW'(1);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    drop_d    = drop_q;
    extract_d = extract_q;
    idx_d     = idx_q;
    node_d    = node_q;
    val_d     = val_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    we        = 1'b0;
    wa        = node_q;
    wd        = val_q;
    ra_a      = node_q;
    ra_b      = idx_q;

    case (state_q)
      // Store incoming words; the closing word starts the sort.
      S_COLLECT: begin
        if (in_acc) begin
          if (count_q < CW'(DEPTH)) begin
            we      = 1'b1;
            wa      = count_q[AW-1:0];
            wd      = in_data_i.data_value;
            count_d = count_inc;
          end else begin
            drop_d = 1'b1;
          end
          if (in_data_i.last_in) begin
            extract_d = 1'b0;
            if (count_d < CW'(2)) begin
              idx_d   = '0;
              state_d = S_EMIT_RD;
            end else begin
              idx_d   = AW'(count_d >> 1);
              node_d  = AW'(count_d >> 1) - AW'(1);
              state_d = S_LOAD;
            end
          end
        end
      end

      // Fetch the value at the node where a build sift-down starts.
      S_LOAD: begin
        ra_a    = node_q;
        state_d = S_LATCH;
      end

      S_LATCH: begin
        val_d   = rd_a_q;
        state_d = S_CHILD;
      end

      // Read both children, or settle the carried value at a leaf.
      S_CHILD: begin
        ra_a = left[AW-1:0];
        ra_b = right[AW-1:0];
        if (left_ok) begin
          state_d = S_CMP;
        end else begin
          we = 1'b1;
          wa = node_q;
          wd = val_q;
          state_d = extract_q ? S_SWAP_RD : S_LOAD;
          if (!extract_q) begin
            if (idx_q > AW'(1)) begin
              idx_d  = idx_q - AW'(1);
              node_d = idx_q - AW'(2);
            end else begin
              extract_d = 1'b1;
              idx_d     = AW'(count_q - CW'(1));
              state_d   = S_SWAP_RD;
            end
          end else if (idx_q > AW'(1)) begin
            idx_d = idx_q - AW'(1);
          end else begin
            idx_d   = '0;
            state_d = S_EMIT_RD;
          end
        end
      end

      // One compare step: move the larger child up or stop here.
      S_CMP: begin
        we = 1'b1;
        wa = node_q;
        if (pick_right) begin
          wd      = rd_b_q;
          node_d  = right[AW-1:0];
          state_d = S_CHILD;
        end else if (!v_gt_l) begin
          wd      = rd_a_q;
          node_d  = left[AW-1:0];
          state_d = S_CHILD;
        end else begin
          wd      = val_q;
          state_d = extract_q ? S_SWAP_RD : S_LOAD;
          if (!extract_q) begin
            if (idx_q > AW'(1)) begin
              idx_d  = idx_q - AW'(1);
              node_d = idx_q - AW'(2);
            end else begin
              extract_d = 1'b1;
              idx_d     = AW'(count_q - CW'(1));
              state_d   = S_SWAP_RD;
            end
          end else if (idx_q > AW'(1)) begin
            idx_d = idx_q - AW'(1);
          end else begin
            idx_d   = '0;
            state_d = S_EMIT_RD;
          end
        end
      end

      // Move the root to the end of the heap and carry the end value down.
      S_SWAP_RD: begin
        ra_a    = '0;
        ra_b    = idx_q;
        state_d = S_SWAP_WR;
      end

      S_SWAP_WR: begin
        we      = 1'b1;
        wa      = idx_q;
        wd      = rd_a_q;
        val_d   = rd_b_q;
        node_d  = '0;
        state_d = S_CHILD;
      end

      // Read the sorted words out in ascending order.
      S_EMIT_RD: begin
        ra_a    = idx_q;
        state_d = S_EMIT_WAIT;
      end

      S_EMIT_WAIT: begin
        ra_a = idx_q;
        if (out_free) begin
          out_vld_d          = 1'b1;
          out_d.sorted_value = rd_a_q;
          out_d.last_out     = emit_last;
          out_d.overflow     = drop_q;
          if (emit_last) begin
            count_d = '0;
            drop_d  = 1'b0;
            state_d = S_COLLECT;
          end else begin
            idx_d   = idx_q + AW'(1);
            state_d = S_EMIT_RD;
          end
        end
      end

      default: begin
        state_d = S_COLLECT;
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_COLLECT);
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

FILE: rtl/core/hs_core_chk.sv
`default_nettype none

module hs_core_chk (
  input wire             clk_i,
  input wire             rst_ni,
  input wire             in_valid_i,
  input wire             in_stall_o,
  input hs_pkg::hs_in_t  in_data_i,
  input wire             out_valid_o,
  input wire             out_stall_i,
  input hs_pkg::hs_out_t out_data_o
);
  import hs_pkg::*;

  // A stalled result word stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result word changed");

  // The closing word of a set starts the sort, so input stalls next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_in |=> in_stall_o)
    else $error("input not stalled after closing word");

  // A word that does not close its set is only stored, or dropped when full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_data_i.last_in |=> !in_stall_o)
    else $error("input stalled after a plain word");

  // Taking the final result while collecting leaves the core collecting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && out_data_o.last_out && !in_stall_o &&
    !(in_valid_i && in_data_i.last_in) |=> !in_stall_o)
    else $error("core busy after final result");

endmodule

bind heap_sorter_core hs_core_chk u_hs_core_chk (.*);

`default_nettype wire
